// ===== src/adsr_pkg.sv =====
// ----------------------------------------------------------------------------
// adsr_pkg: shared types and constants for the ADSR envelope generator
// Level format Q1.24 (1.0 = 2^24), coefficients Q8.24, phase codes.
// ----------------------------------------------------------------------------
package adsr_pkg;

    localparam int LVL_W  = 25;
    localparam int COEF_W = 32;
    localparam int FRAC_W = 24;
    localparam int EXT_W  = COEF_W + 1;
    localparam int PROD_W = LVL_W + COEF_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COEF_W;

    localparam logic [LVL_W-1:0] LVL_ONE   = LVL_W'(1) << FRAC_W;
    // 0.0001 rounded to the nearest Q.24 step
    localparam logic [LVL_W-1:0] LVL_FLOOR = LVL_W'(1678);

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EXP_MODE      = 3'd0,
        REG_ATTACK_COEF   = 3'd1,
        REG_DECAY_COEF    = 3'd2,
        REG_SUSTAIN_LEVEL = 3'd3,
        REG_RELEASE_COEF  = 3'd4
    } t_reg_idx;

endpackage

// ===== src/adsr_stream_if.sv =====
// ----------------------------------------------------------------------------
// adsr_stream_if: valid/ready channels for gate ticks and envelope results
// adsr_in_if carries one gate sample, adsr_out_if one level/phase result.
// ----------------------------------------------------------------------------
interface adsr_in_if;
    logic valid;
    logic ready;
    logic gate;

    modport source (output valid, output gate, input ready);
    modport sink   (input valid, input gate, output ready);
endinterface

interface adsr_out_if;
    logic                         valid;
    logic                         ready;
    logic [adsr_pkg::LVL_W-1:0]   level;
    adsr_pkg::t_phase             phase;

    modport source (output valid, output level, output phase, input ready);
    modport sink   (input valid, input level, input phase, output ready);
endinterface

// ===== src/adsr_envelope_generator.sv =====
// ----------------------------------------------------------------------------
// adsr_envelope_generator: ADSR envelope, one update per sample tick
// Gate edges start attack or release; linear or exponential steps.
// ----------------------------------------------------------------------------
// Usage:
//   i_in   : one request per audio tick carrying the gate level.
//   o_out  : one result per tick: the level after the step (Q1.24, 1.0 =
//            2^24) and the phase code.
//   i_cfg_*: register writes (index 0 mode, 1 attack, 2 decay, 3 sustain,
//            4 release); write only while no request is in flight.
// The gate is captured in an input register; edge detect, one 25x32
// multiply or add/subtract, compare and clamp then run combinationally
// into the result register.
// Throughput is one request per cycle while the receiver takes each
// result; the envelope state is updated by the same cycle that loads the
// result register, so the recurrence closes through the shared multiplier.
// Reset clears the envelope (level 0, idle, gate low), the config registers
// to 0, and empties both stages.
// A stalled receiver holds the result register; the input register still
// fills, then i_in.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module adsr_envelope_generator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    adsr_in_if.sink                             i_in,
    adsr_out_if.source                          o_out,
    input  logic                                i_cfg_we,
    input  logic [adsr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [adsr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int LVL_W  = adsr_pkg::LVL_W;
    localparam int COEF_W = adsr_pkg::COEF_W;
    localparam int EXT_W  = adsr_pkg::EXT_W;
    localparam int PROD_W = adsr_pkg::PROD_W;
    localparam int FRAC_W = adsr_pkg::FRAC_W;

    // configuration
    logic                r_exp_mode;
    logic [COEF_W-1:0]   r_attack_coef;
    logic [COEF_W-1:0]   r_decay_coef;
    logic [LVL_W-1:0]    r_sustain;
    logic [COEF_W-1:0]   r_release_coef;

    // envelope state
    logic [LVL_W-1:0]    r_level;
    adsr_pkg::t_phase    r_phase;
    logic                r_last_gate;

    // pipeline
    logic                r_in_valid;
    logic                r_in_gate;
    logic                r_out_valid;
    logic [LVL_W-1:0]    r_out_level;
    adsr_pkg::t_phase    r_out_phase;

    logic                s_adv;
    logic                s_in_fire;

    logic                n_edge;
    logic [LVL_W-1:0]    n_lvl0;
    adsr_pkg::t_phase    n_ph0;
    logic [COEF_W-1:0]   n_coef;
    logic [LVL_W-1:0]    n_sus;
    logic [LVL_W-1:0]    n_limit;
    logic [PROD_W-1:0]   n_prod;
    logic [EXT_W-1:0]    n_mul;
    logic [EXT_W-1:0]    n_sum;
    logic [EXT_W-1:0]    n_sub;
    logic                n_below;
    logic [EXT_W-1:0]    n_v;
    adsr_pkg::t_phase    n_phase;
    logic [LVL_W-1:0]    n_level;

    assign s_adv     = r_in_valid && (!r_out_valid || o_out.ready);
    assign s_in_fire = i_in.valid && i_in.ready;

    assign i_in.ready  = !r_in_valid || s_adv;
    assign o_out.valid = r_out_valid;
    assign o_out.level = r_out_level;
    assign o_out.phase = r_out_phase;

    always_comb begin
        n_edge = r_in_gate != r_last_gate;
        n_lvl0 = (n_edge && r_in_gate) ? adsr_pkg::LVL_FLOOR : r_level;
        if (n_edge) begin
            n_ph0 = r_in_gate ? adsr_pkg::PH_ATTACK : adsr_pkg::PH_RELEASE;
        end else begin
            n_ph0 = r_phase;
        end

        case (n_ph0)
            adsr_pkg::PH_ATTACK: n_coef = r_attack_coef;
            adsr_pkg::PH_DECAY:  n_coef = r_decay_coef;
            default:             n_coef = r_release_coef;
        endcase

        n_sus   = (r_sustain > adsr_pkg::LVL_ONE) ? adsr_pkg::LVL_ONE : r_sustain;
        n_limit = (n_ph0 == adsr_pkg::PH_DECAY) ? n_sus : adsr_pkg::LVL_FLOOR;

        n_prod = PROD_W'(n_lvl0) * PROD_W'(n_coef);
        n_mul  = n_prod[PROD_W-1:FRAC_W];
        n_sum  = EXT_W'(n_lvl0) + EXT_W'(n_coef);
        n_sub  = EXT_W'(n_lvl0) - EXT_W'(n_coef);

        if (r_exp_mode) begin
            n_below = n_mul <= EXT_W'(n_limit);
        end else begin
            n_below = (EXT_W'(n_coef) >= EXT_W'(n_lvl0)) || (n_sub <= EXT_W'(n_limit));
        end

        n_phase = n_ph0;
        n_v     = EXT_W'(n_lvl0);
        case (n_ph0)
            adsr_pkg::PH_ATTACK: begin
                n_v = r_exp_mode ? n_mul : n_sum;
                if (n_v >= EXT_W'(adsr_pkg::LVL_ONE)) begin
                    n_v     = EXT_W'(adsr_pkg::LVL_ONE);
                    n_phase = adsr_pkg::PH_DECAY;
                end
            end
            adsr_pkg::PH_DECAY: begin
                if (n_below) begin
                    n_v     = EXT_W'(n_sus);
                    n_phase = adsr_pkg::PH_SUSTAIN;
                end else begin
                    n_v = r_exp_mode ? n_mul : n_sub;
                end
            end
            adsr_pkg::PH_RELEASE: begin
                if (n_below) begin
                    n_v     = '0;
                    n_phase = adsr_pkg::PH_IDLE;
                end else begin
                    n_v = r_exp_mode ? n_mul : n_sub;
                end
            end
            default: begin
                n_v = EXT_W'(n_lvl0);
            end
        endcase

        // exponential decay with a factor above one can overshoot
        n_level = (n_v > EXT_W'(adsr_pkg::LVL_ONE)) ? adsr_pkg::LVL_ONE : n_v[LVL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_mode     <= 1'b0;
            r_attack_coef  <= '0;
            r_decay_coef   <= '0;
            r_sustain      <= '0;
            r_release_coef <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                adsr_pkg::REG_EXP_MODE:      r_exp_mode     <= i_cfg_data[0];
                adsr_pkg::REG_ATTACK_COEF:   r_attack_coef  <= i_cfg_data;
                adsr_pkg::REG_DECAY_COEF:    r_decay_coef   <= i_cfg_data;
                adsr_pkg::REG_SUSTAIN_LEVEL: r_sustain      <= i_cfg_data[LVL_W-1:0];
                adsr_pkg::REG_RELEASE_COEF:  r_release_coef <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_level     <= '0;
            r_phase     <= adsr_pkg::PH_IDLE;
            r_last_gate <= 1'b0;
        end else begin
            if (s_in_fire) begin
                r_in_valid <= 1'b1;
            end else if (s_adv) begin
                r_in_valid <= 1'b0;
            end

            if (s_adv) begin
                r_out_valid <= 1'b1;
                r_level     <= n_level;
                r_phase     <= n_phase;
                r_last_gate <= r_in_gate;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_in_fire) begin
            r_in_gate <= i_in.gate;
        end
        if (s_adv) begin
            r_out_level <= n_level;
            r_out_phase <= n_phase;
        end
    end

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_level <= adsr_pkg::LVL_ONE))
        else $error("envelope level above 1.0");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == adsr_pkg::PH_IDLE) |-> (r_level == '0))
        else $error("idle phase with nonzero level");

    a_gate_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == adsr_pkg::PH_ATTACK) || (r_phase == adsr_pkg::PH_DECAY) ||
         (r_phase == adsr_pkg::PH_SUSTAIN)) |-> r_last_gate)
        else $error("gated phase with gate low");

    a_release_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == adsr_pkg::PH_RELEASE) |-> !r_last_gate)
        else $error("release phase with gate high");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_adv |=> ($stable(r_level) && $stable(r_phase) && $stable(r_last_gate)))
        else $error("envelope state moved without a step");

endmodule
